// ===== rtl/mat4_vec4_transform_assert.svh =====
// Assertion macros for the mat4_vec4_transform block.
// Included by the top level, which checks its own pipeline control.
`ifndef MAT4_VEC4_TRANSFORM_ASSERT_SVH
`define MAT4_VEC4_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define M4V4_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m4v4 same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define M4V4_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m4v4 next-cycle check failed");

`endif

// ===== rtl/m4v4_pkg.sv =====
// Shared constants, types and binary32 helpers for mat4_vec4_transform.
// No dependencies; imported by the multiplier, adder and top level.
`timescale 1ns / 1ps
package m4v4_pkg;

  localparam int unsigned NUM_PAIRS  = 8;
  localparam int unsigned NUM_STAGES = 8;
  localparam int unsigned CFG_IDX_W  = 4;

  localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
  localparam logic [30:0] FP_INF_MAG  = 31'h7F80_0000;
  localparam logic [31:0] FP_ONE      = 32'h3F80_0000;

  // Identity matrix, two elements per register
  localparam logic [63:0] CFG_RESET [NUM_PAIRS] = '{
    {32'h0, FP_ONE}, 64'h0, {FP_ONE, 32'h0}, 64'h0,
    64'h0, {32'h0, FP_ONE}, 64'h0, {FP_ONE, 32'h0}
  };

  // Load enables of a two-stage arithmetic unit
  typedef struct packed {
    logic s_a;
    logic s_b;
  } stg_en_t;

  // Leading zero count of a 48-bit word (48 when zero)
  function automatic logic [5:0] lzc48(input logic [47:0] x);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // Round to nearest even and pack. m has its leading one at bit 47;
  // value = m / 2^47 * 2^(e - 127).
  function automatic logic [31:0] fp_round_pack(input logic sgn,
                                                input logic signed [11:0] e,
                                                input logic [47:0] m);
    logic [47:0] ext;
    logic        lost;
    logic [5:0]  sh;
    logic signed [11:0] shs;
    logic [23:0] keep;
    logic        g;
    logic        st;
    logic        inc;
    logic [7:0]  ef;
    logic [30:0] mag;
    ext  = m;
    lost = 1'b0;
    ef   = e[7:0];
    sh   = '0;
    shs  = '0;
    // Denormalize when below the normal range
    if (e < 12'sd1) begin
      shs = 12'sd1 - e;
      sh  = (shs > 12'sd47) ? 6'd47 : shs[5:0];
      lost = |(m & ((48'd1 << sh) - 48'd1));
      ext  = m >> sh;
      ef   = '0;
    end
    keep = ext[47:24];
    g    = ext[23];
    st   = (|ext[22:0]) | lost;
    inc  = g & (st | keep[0]);
    mag  = {ef, keep[22:0]} + {30'd0, inc};
    if (e > 12'sd254) return {sgn, FP_INF_MAG};
    return {sgn, mag};
  endfunction

endpackage

// ===== rtl/m4v4_fmul.sv =====
// Two-stage binary32 multiplier: significand product, then normalize and round.
// Depends on m4v4_pkg.
`timescale 1ns / 1ps
module m4v4_fmul import m4v4_pkg::*; (
  input  logic        clk_i,
  input  stg_en_t     en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;

  logic        sgn_q, nan_q, inf_q, zero_q;
  logic signed [11:0] esum_q;
  logic [47:0] prod_q;
  logic [31:0] p_q, p_d;
  logic [5:0]  lz;
  logic [47:0] norm;
  logic signed [11:0] e_norm;

  // Classify operands
  always_comb begin
    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != '0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != '0);
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == '0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == '0);
    a_zero = (a_i[30:0] == '0);
    b_zero = (b_i[30:0] == '0);
    ea     = (a_i[30:23] == '0) ? 8'd1 : a_i[30:23];
    eb     = (b_i[30:23] == '0) ? 8'd1 : b_i[30:23];
    ma     = {a_i[30:23] != '0, a_i[22:0]};
    mb     = {b_i[30:23] != '0, b_i[22:0]};
  end

  // Stage A: significand product and exponent sum
  always_ff @(posedge clk_i) begin
    if (en_i.s_a) begin
      sgn_q  <= a_i[31] ^ b_i[31];
      nan_q  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      inf_q  <= a_inf | b_inf;
      zero_q <= a_zero | b_zero;
      esum_q <= $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd127;
      prod_q <= ma * mb;
    end
  end

  // Stage B: normalize and round
  always_comb begin
    lz     = lzc48(prod_q);
    norm   = prod_q << lz;
    e_norm = esum_q + 12'sd1 - $signed({6'd0, lz});
    if (nan_q)       p_d = CANON_NAN;
    else if (inf_q)  p_d = {sgn_q, FP_INF_MAG};
    else if (zero_q) p_d = {sgn_q, 31'd0};
    else             p_d = fp_round_pack(sgn_q, e_norm, norm);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s_b) p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== rtl/m4v4_fadd.sv =====
// Two-stage binary32 adder: align and add, then normalize and round.
// Depends on m4v4_pkg.
`timescale 1ns / 1ps
module m4v4_fadd import m4v4_pkg::*; (
  input  logic        clk_i,
  input  stg_en_t     en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] s_o
);

  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [31:0] big, sml;
  logic [7:0]  eb, es, d;
  logic [26:0] abig, bx, bsh;
  logic        lost;
  logic [27:0] sum_d;

  logic        sgn_q, zs_q, nan_q, inf_q, isgn_q;
  logic [7:0]  e_q;
  logic [27:0] sum_q;
  logic [31:0] s_q, s_d;
  logic [5:0]  lz;
  logic [47:0] norm;
  logic signed [11:0] e_norm;

  // Order by magnitude and align the smaller operand
  always_comb begin
    a_nan = (a_i[30:23] == 8'hFF) && (a_i[22:0] != '0);
    b_nan = (b_i[30:23] == 8'hFF) && (b_i[22:0] != '0);
    a_inf = (a_i[30:23] == 8'hFF) && (a_i[22:0] == '0);
    b_inf = (b_i[30:23] == 8'hFF) && (b_i[22:0] == '0);
    swap  = b_i[30:0] > a_i[30:0];
    big   = swap ? b_i : a_i;
    sml   = swap ? a_i : b_i;
    eb    = (big[30:23] == '0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    d     = eb - es;
    abig  = {big[30:23] != '0, big[22:0], 3'b000};
    bx    = {sml[30:23] != '0, sml[22:0], 3'b000};
    if (d >= 8'd27) begin
      bsh  = {26'd0, |bx};
      lost = 1'b0;
    end else begin
      lost = |(bx & ((27'd1 << d) - 27'd1));
      bsh  = (bx >> d) | {26'd0, lost};
    end
    if (big[31] ^ sml[31]) sum_d = {1'b0, abig} - {1'b0, bsh};
    else                   sum_d = {1'b0, abig} + {1'b0, bsh};
  end

  // Stage A: raw sum
  always_ff @(posedge clk_i) begin
    if (en_i.s_a) begin
      sgn_q  <= big[31];
      zs_q   <= a_i[31] & b_i[31];
      nan_q  <= a_nan | b_nan | (a_inf & b_inf & (a_i[31] ^ b_i[31]));
      inf_q  <= a_inf | b_inf;
      isgn_q <= a_inf ? a_i[31] : b_i[31];
      e_q    <= eb;
      sum_q  <= sum_d;
    end
  end

  // Stage B: normalize and round
  always_comb begin
    lz     = lzc48({sum_q, 20'd0});
    norm   = {sum_q, 20'd0} << lz;
    e_norm = $signed({4'd0, e_q}) + 12'sd1 - $signed({6'd0, lz});
    if (nan_q)               s_d = CANON_NAN;
    else if (inf_q)          s_d = {isgn_q, FP_INF_MAG};
    else if (sum_q == '0)    s_d = {zs_q, 31'd0};
    else                     s_d = fp_round_pack(sgn_q, e_norm, norm);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s_b) s_q <= s_d;
  end

  assign s_o = s_q;

endmodule

// ===== rtl/mat4_vec4_transform.sv =====
// Usage: transforms binary32 4-vectors by a column-major 4x4 binary32 matrix.
// Input words arrive on s_axis (tdata = x, y, z, w from bit 0 up, 32 bits each);
// each yields one output word on m_axis in the same packing (rows 0..3).
// The matrix sits in eight 64-bit registers written through cfg_we_i /
// cfg_idx_i / cfg_data_i; register i holds elements 2i (low) and 2i+1 (high).
// Write it only while the pipeline is empty; indexes above 7 are ignored.
// Each row is m[r]*x + m[4+r]*y, then + m[8+r]*z, then + m[12+r]*w, each
// operation rounded to nearest even; NaN results come out as 0x7FC00000.
// From input accept to m_axis_tvalid a word passes two multiplier stages,
// then three two-stage adders in a chain; the last stage is the output
// register. Throughput: one word per cycle while m_axis_tready is high.
// A stall on m_axis holds the output register; earlier stages keep
// filling empty slots, so s_axis_tready drops only when all stages are full.
// Reset clears every stage valid bit and loads the identity matrix.
// Depends on m4v4_pkg, m4v4_fmul, m4v4_fadd.
`timescale 1ns / 1ps
`include "mat4_vec4_transform_assert.svh"
module mat4_vec4_transform import m4v4_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [127:0]         s_axis_tdata,  // in_x, in_y, in_z, in_w
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [127:0]         m_axis_tdata,  // out_x, out_y, out_z, out_w
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]          cfg_data_i
);

  logic [63:0]           pair_q [NUM_PAIRS];
  logic [31:0]           elem [16];
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;
  stg_en_t               en_mul, en_a1, en_a2, en_a3;

  logic [31:0] prod [4][4];
  logic [31:0] p2_q2 [4];
  logic [31:0] p2_q3 [4];
  logic [31:0] p3_q2 [4];
  logic [31:0] p3_q3 [4];
  logic [31:0] p3_q4 [4];
  logic [31:0] p3_q5 [4];
  logic [31:0] s1 [4];
  logic [31:0] s2 [4];
  logic [31:0] s3 [4];

  // Matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PAIRS; i++) pair_q[i] <= CFG_RESET[i];
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_PAIRS))) begin
      pair_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_PAIRS; i++) begin
      elem[2*i]   = pair_q[i][31:0];
      elem[2*i+1] = pair_q[i][63:32];
    end
  end

  // Stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign en_mul = '{s_a: en[0], s_b: en[1]};
  assign en_a1  = '{s_a: en[2], s_b: en[3]};
  assign en_a2  = '{s_a: en[4], s_b: en[5]};
  assign en_a3  = '{s_a: en[6], s_b: en[7]};

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      m4v4_fmul u_mul (
        .clk_i (clk_i),
        .en_i  (en_mul),
        .a_i   (elem[4*c+r]),
        .b_i   (s_axis_tdata[32*c +: 32]),
        .p_o   (prod[r][c])
      );
    end

    // Hold the later products until their adder comes up
    always_ff @(posedge clk_i) begin
      if (en[2]) begin
        p2_q2[r] <= prod[r][2];
        p3_q2[r] <= prod[r][3];
      end
      if (en[3]) begin
        p2_q3[r] <= p2_q2[r];
        p3_q3[r] <= p3_q2[r];
      end
      if (en[4]) p3_q4[r] <= p3_q3[r];
      if (en[5]) p3_q5[r] <= p3_q4[r];
    end

    m4v4_fadd u_add1 (
      .clk_i (clk_i),
      .en_i  (en_a1),
      .a_i   (prod[r][0]),
      .b_i   (prod[r][1]),
      .s_o   (s1[r])
    );

    m4v4_fadd u_add2 (
      .clk_i (clk_i),
      .en_i  (en_a2),
      .a_i   (s1[r]),
      .b_i   (p2_q3[r]),
      .s_o   (s2[r])
    );

    m4v4_fadd u_add3 (
      .clk_i (clk_i),
      .en_i  (en_a3),
      .a_i   (s2[r]),
      .b_i   (p3_q5[r]),
      .s_o   (s3[r])
    );
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NUM_STAGES-1];
  assign m_axis_tdata  = {s3[3], s3[2], s3[1], s3[0]};

  `M4V4_ASSERT_NXT(a_accept_fills, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, v_q[0])
  `M4V4_ASSERT_NXT(a_mid_hold, clk_i, rst_ni, v_q[4] && !en[4], v_q[4])
  `M4V4_ASSERT_IMP(a_ready_room, clk_i, rst_ni, s_axis_tready, !(&v_q) || m_axis_tready)
  `M4V4_ASSERT_IMP(a_stall_full, clk_i, rst_ni, !en[3], v_q[3] && v_q[7])

endmodule
